### design/phe_pkg.sv
// Shared types, codes and constant tables for the polynomial curve evaluator.
package phe_pkg;

	localparam int COEF_W = 32;
	localparam int ACC_W  = 48;
	localparam int FACT_W = 13;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DOMAIN = 2'd1,
		ST_SAT    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_DEGREE   = 2'd0,
		REG_DOM_LOW  = 2'd1,
		REG_DOM_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRD,
		S_TERM,
		S_TADD,
		S_MABS,
		S_MLO,
		S_MHI,
		S_MSUM,
		S_MRND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [2:0]        idx;
		logic [COEF_W-1:0] x;
		logic [COEF_W-1:0] y;
		logic [COEF_W-1:0] z;
	} tab_wr_t;

	typedef struct packed {
		logic [2:0] addr;
		axis_t      axis;
	} tab_rd_t;

	typedef struct packed {
		logic              neg;
		logic [COEF_W-1:0] mag;
	} tab_out_t;

	// (j+k)!/j! for j+k <= 7, indexed by {j,k}
	function automatic logic [64*FACT_W-1:0] fall_build();
		logic [64*FACT_W-1:0] tab;
		int f;
		tab = '0;
		for (int j = 0; j < 8; j++) begin
			for (int k = 0; k < 8; k++) begin
				f = 1;
				for (int i = 1; i <= k; i++) begin
					f = f * (j + i);
				end
				if (j + k <= 7) begin
					tab[(j*8+k)*FACT_W +: FACT_W] = FACT_W'(f);
				end
			end
		end
		return tab;
	endfunction

	localparam logic [64*FACT_W-1:0] FALL_TAB = fall_build();

	function automatic logic [FACT_W-1:0] fall_of(input logic [2:0] j, input logic [2:0] k);
		return FALL_TAB[{j, k}*FACT_W +: FACT_W];
	endfunction

endpackage

### design/poly_curve_horner_eval.sv
// Horner evaluator of a 3D polynomial curve or its derivative in fixed point.
// Load request: no result. Evaluate request outside the domain or with order above
// degree: result without any Horner step. Otherwise the result follows the Horner steps for
// x, y and z in turn; each step uses the one shared 32x32 multiplier for the term and, but for
// an axis's last step, for the low and high partial products. One request at a time.
// arst_n clears control and the degree/domain registers; the table is not cleared.
module poly_curve_horner_eval import phe_pkg::*; #(
	parameter int MAX_DEGREE = 7,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // coef_index, coef_x, coef_y, coef_z, param_t, deriv_order
	input  logic [0:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // res_x, res_y, res_z
	output logic [1:0]   m_tuser    // status
);

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam logic [79:0] HALF    = 80'(1) << (FRAC_BITS - 1);
	localparam logic [79:0] LIM_POS = (80'(1) << 47) - 80'(1);
	localparam logic [79:0] LIM_NEG = 80'(1) << 47;
	localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	state_t state_q, state_d;

	logic [2:0]  cfg_degree_q;
	logic signed [31:0] dom_lo_q, dom_hi_q;

	logic [2:0]  in_idx;
	logic [31:0] in_x, in_y, in_z;
	logic signed [31:0] in_t;
	logic [2:0]  in_k;
	op_t         in_op;
	logic        in_acc;
	logic        in_dom_err;
	logic [2:0]  deg;

	axis_t       axis_q;
	logic [2:0]  j_q, k_q, top_q;
	logic        first_q;
	logic        sat_q;
	logic        dom_err_q;
	logic        t_neg_q;
	logic [31:0] ut_q;
	logic [47:0] ua_q;
	logic        negm_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [63:0] mul_q;
	logic [55:0] plo_q;
	logic [79:0] sum_q;
	logic signed [ACC_W-1:0] rx_q, ry_q, rz_q;
	logic         m_tvalid_q;
	logic [143:0] m_tdata_q;
	logic [1:0]   m_tuser_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic signed [ACC_W:0]   add_s;
	logic signed [ACC_W:0]   add_base;
	logic                    add_ov;
	logic signed [ACC_W-1:0] add_val;
	logic [79:0]             rmag;
	logic                    rnd_ov;
	logic signed [ACC_W-1:0] rnd_val;
	logic                    out_free;
	status_t                 status;

	tab_wr_t  tab_wr;
	tab_rd_t  tab_rd;
	tab_out_t tab_q;

	assign in_idx = s_tdata[2:0];
	assign in_x   = s_tdata[34:3];
	assign in_y   = s_tdata[66:35];
	assign in_z   = s_tdata[98:67];
	assign in_t   = s_tdata[130:99];
	assign in_k   = s_tdata[133:131];
	assign in_op  = op_t'(s_tuser[0]);

	assign s_tready   = (state_q == S_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign in_dom_err = (in_t < dom_lo_q) || (in_t > dom_hi_q);
	assign deg        = (32'(cfg_degree_q) > MAX_DEGREE) ? 3'(MAX_DEGREE) : cfg_degree_q;
	assign out_free   = !m_tvalid_q || m_tready;

	assign tab_wr.we   = in_acc && (in_op == OP_LOAD);
	assign tab_wr.idx  = in_idx;
	assign tab_wr.x    = in_x;
	assign tab_wr.y    = in_y;
	assign tab_wr.z    = in_z;
	assign tab_rd.addr = j_q + k_q;
	assign tab_rd.axis = axis_q;

	phe_coef_tab #(
		.DEPTH (DEPTH)
	) u_tab (
		.clk  (clk),
		.wr   (tab_wr),
		.rd   (tab_rd),
		.rd_q (tab_q)
	);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TERM: begin
				mul_a = tab_q.mag;
				mul_b = 32'(fall_of(j_q, k_q));
			end
			S_MLO: begin
				mul_a = 32'(ua_q[23:0]);
				mul_b = ut_q;
			end
			S_MHI: begin
				mul_a = 32'(ua_q[47:24]);
				mul_b = ut_q;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// term accumulate with saturation
	always_comb begin
		add_base = first_q ? '0 : {acc_q[ACC_W-1], acc_q};
		if (tab_q.neg) begin
			add_s = add_base - $signed({1'b0, mul_q[ACC_W-1:0]});
		end else begin
			add_s = add_base + $signed({1'b0, mul_q[ACC_W-1:0]});
		end
		add_ov  = add_s[ACC_W] != add_s[ACC_W-1];
		add_val = add_ov ? (add_s[ACC_W] ? SAT_MIN : SAT_MAX) : add_s[ACC_W-1:0];
	end

	// rounded product scale and saturation
	always_comb begin
		rmag   = sum_q >> FRAC_BITS;
		rnd_ov = negm_q ? (rmag > LIM_NEG) : (rmag > LIM_POS);
		if (rnd_ov) begin
			rnd_val = negm_q ? SAT_MIN : SAT_MAX;
		end else if (negm_q) begin
			rnd_val = ~rmag[ACC_W-1:0] + ACC_W'(1);
		end else begin
			rnd_val = rmag[ACC_W-1:0];
		end
	end

	always_comb begin
		if (dom_err_q) begin
			status = ST_DOMAIN;
		end else if (sat_q) begin
			status = ST_SAT;
		end else begin
			status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (in_op == OP_EVAL)) begin
					state_d = (in_dom_err || (in_k > deg)) ? S_DONE : S_TRD;
				end
			end
			S_TRD:  state_d = S_TERM;
			S_TERM: state_d = S_TADD;
			S_TADD: begin
				if (j_q == 3'd0) begin
					state_d = (axis_q == AX_Z) ? S_DONE : S_TRD;
				end else begin
					state_d = S_MABS;
				end
			end
			S_MABS: state_d = S_MLO;
			S_MLO:  state_d = S_MHI;
			S_MHI:  state_d = S_MSUM;
			S_MSUM: state_d = S_MRND;
			S_MRND: state_d = S_TERM;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_degree_q <= '0;
			dom_lo_q     <= 32'sd0;
			dom_hi_q     <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_DEGREE:   cfg_degree_q <= cfg_wdata[2:0];
				REG_DOM_LOW:  dom_lo_q     <= cfg_wdata;
				REG_DOM_HIGH: dom_hi_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q    <= AX_X;
			j_q       <= '0;
			k_q       <= '0;
			top_q     <= '0;
			first_q   <= 1'b1;
			sat_q     <= 1'b0;
			dom_err_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_op == OP_EVAL)) begin
						axis_q    <= AX_X;
						k_q       <= in_k;
						j_q       <= deg - in_k;
						top_q     <= deg - in_k;
						first_q   <= 1'b1;
						sat_q     <= 1'b0;
						dom_err_q <= in_dom_err;
					end
				end
				S_TADD: begin
					sat_q <= sat_q | add_ov;
					if (j_q == 3'd0) begin
						first_q <= 1'b1;
						j_q     <= top_q;
						axis_q  <= (axis_q == AX_X) ? AX_Y : AX_Z;
					end else begin
						first_q <= 1'b0;
						j_q     <= j_q - 3'd1;
					end
				end
				S_MRND: sat_q <= sat_q | rnd_ov;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && (in_op == OP_EVAL)) begin
					t_neg_q <= in_t[31];
					ut_q    <= in_t[31] ? (~in_t + 32'sd1) : in_t;
					rx_q    <= '0;
					ry_q    <= '0;
					rz_q    <= '0;
				end
			end
			S_TERM: mul_q <= mul_p;
			S_TADD: begin
				acc_q <= add_val;
				if (j_q == 3'd0) begin
					case (axis_q)
						AX_X:    rx_q <= add_val;
						AX_Y:    ry_q <= add_val;
						default: rz_q <= add_val;
					endcase
				end
			end
			S_MABS: begin
				ua_q   <= acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
				negm_q <= acc_q[ACC_W-1] ^ t_neg_q;
			end
			S_MLO: mul_q <= mul_p;
			S_MHI: begin
				plo_q <= mul_q[55:0];
				mul_q <= mul_p;
			end
			S_MSUM: sum_q <= {mul_q[55:0], 24'd0} + 80'(plo_q) + HALF;
			S_MRND: acc_q <= rnd_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= {rz_q, ry_q, rx_q};
			m_tuser_q <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### design/phe_coef_tab.sv
// Coefficient table for x, y and z with a registered magnitude and sign read port.
module phe_coef_tab import phe_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic     clk,
	input  tab_wr_t  wr,
	input  tab_rd_t  rd,
	output tab_out_t rd_q
);

	localparam int IW = $clog2(DEPTH);

	logic [COEF_W-1:0] tx_q [DEPTH];
	logic [COEF_W-1:0] ty_q [DEPTH];
	logic [COEF_W-1:0] tz_q [DEPTH];
	logic [IW-1:0]     waddr;
	logic [IW-1:0]     raddr;
	logic [COEF_W-1:0] sel;

	assign waddr = IW'(wr.idx);
	assign raddr = IW'(rd.addr);

	always_ff @(posedge clk) begin
		if (wr.we && (32'(wr.idx) < DEPTH)) begin
			tx_q[waddr] <= wr.x;
			ty_q[waddr] <= wr.y;
			tz_q[waddr] <= wr.z;
		end
	end

	always_comb begin
		unique case (rd.axis)
			AX_X:    sel = tx_q[raddr];
			AX_Y:    sel = ty_q[raddr];
			AX_Z:    sel = tz_q[raddr];
			default: sel = tx_q[raddr];
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q.neg <= sel[COEF_W-1];
		rd_q.mag <= sel[COEF_W-1] ? (~sel + COEF_W'(1)) : sel;
	end

endmodule
